/* hdl/arrb_pkg.sv */
// Shared types, action codes and sequence compare helpers for the retransmit ring.
package arrb_pkg;

    // Action codes carried in an input item
    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_PEEK   = 3'd1;
    localparam logic [2:0] ACT_COMMIT = 3'd2;
    localparam logic [2:0] ACT_ACK    = 3'd3;
    localparam logic [2:0] ACT_REWIND = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] sample_low;
        logic [31:0] sample_high;
        logic [6:0]  max_count;
        logic [31:0] commit_base;
        logic [31:0] commit_count;
        logic [31:0] ack_mark;
    } t_in_item;

    typedef struct packed {
        logic        sample_valid;
        logic [31:0] sample_seq;
        logic [63:0] out_low;
        logic [31:0] out_high;
        logic [31:0] batch_base;
        logic [6:0]  batch_count;
        logic        last;
        logic [9:0]  pending;
        logic [9:0]  unacked;
        logic        gap_seen;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_PEEK,
        OP_COMMIT,
        OP_ACK,
        OP_REWIND,
        OP_CLEAR,
        OP_NOP
    } t_op;

    // Classified command handed from front to back
    typedef struct packed {
        t_op         op;
        logic [95:0] payload;
        logic [6:0]  limit;
        logic [31:0] arg;
    } t_cmd;

    // a is after b in modular sequence order
    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    // a is at or after b in modular sequence order
    function automatic logic seq_not_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

endpackage

/* hdl/acked_retransmit_ring_buffer.sv */
// Top level of the acknowledged retransmit ring buffer.
// An item is taken when start is high and busy is low; a two-entry queue sits
// between the decoder and the execution unit, and busy is high only while that
// queue is full. A taken item waits in the queue until the execution unit is
// idle. A push, commit, ack, rewind, clear, unused action or empty peek is done
// by the unit as it takes it, and its status result is on the ports in the
// cycle after that, so these items can follow one per cycle. A peek sizes the
// batch as the unit takes it, then makes one read of the single sample memory
// port per cycle; each sample is registered as it is read and leaves in the
// cycle after its read, so the samples follow one per cycle. Each result is
// valid for exactly one cycle on o_result_valid and cannot be stalled. The
// sample memory has no clearing pass and is usable right after reset.
module acked_retransmit_ring_buffer
    import arrb_pkg::*;
#(
    parameter int RING_DEPTH = 768,
    parameter int MAX_BATCH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_result_valid,
    output t_out_item o_result
);

    logic q_full;
    logic q_avail;
    logic q_push;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    arrb_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .i_start (start),
        .i_full  (q_full),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    arrb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_cmd   (back_cmd)
    );

    arrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_cmd          (back_cmd),
        .o_pop          (q_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

/* hdl/arrb_front.sv */
// Front end: accepts input items and classifies them into back-end commands.
module arrb_front
    import arrb_pkg::*;
#(
    parameter int MAX_BATCH = 64
) (
    input  logic     i_start,
    input  logic     i_full,
    input  t_in_item i_item,
    output logic     o_busy,
    output logic     o_push,
    output t_cmd     o_cmd
);

    // Accept an item whenever the queue has room
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // Decode the action and precompute the operand the back end needs
    always_comb begin
        o_cmd.payload = {i_item.sample_high, i_item.sample_low};
        o_cmd.limit   = (i_item.max_count > 7'(MAX_BATCH)) ? 7'(MAX_BATCH)
                                                           : i_item.max_count;
        o_cmd.arg     = '0;
        case (i_item.action)
            ACT_PUSH: begin
                o_cmd.op = OP_PUSH;
            end
            ACT_PEEK: begin
                o_cmd.op = OP_PEEK;
            end
            ACT_COMMIT: begin
                o_cmd.op  = OP_COMMIT;
                o_cmd.arg = i_item.commit_base + i_item.commit_count;
            end
            ACT_ACK: begin
                o_cmd.op  = OP_ACK;
                o_cmd.arg = i_item.ack_mark + 32'd1;
            end
            ACT_REWIND: begin
                o_cmd.op = OP_REWIND;
            end
            ACT_CLEAR: begin
                o_cmd.op = OP_CLEAR;
            end
            default: begin
                o_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

/* hdl/arrb_fifo.sv */
// Short command queue between the front end and the back end.
module arrb_fifo
    import arrb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_avail,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   n_rptr;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* hdl/arrb_back.sv */
// Back end: pointer updates, sample store and batch emission.
module arrb_back
    import arrb_pkg::*;
#(
    parameter int RING_DEPTH = 768
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_avail,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_result_valid,
    output t_out_item o_result
);

    localparam int SW = $clog2(RING_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_PEEK
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_write, n_write;
    logic [31:0]   r_ack, n_ack;
    logic [31:0]   r_send, n_send;
    logic          r_gap, n_gap;
    logic [SW-1:0] r_wslot, n_wslot;
    logic [SW-1:0] r_slot, n_slot;
    logic [31:0]   r_seq, n_seq;
    logic [6:0]    r_k, n_k;
    logic [6:0]    r_n, n_n;
    logic [31:0]   r_base, n_base;
    logic          r_pk_valid, n_pk_valid;
    logic [31:0]   r_pk_seq, n_pk_seq;
    logic          r_pk_last, n_pk_last;
    logic          r_st_valid, n_st_valid;
    logic [31:0]   r_st_base, n_st_base;

    logic [95:0]   r_store [RING_DEPTH];
    logic [95:0]   r_rd_data;
    logic          wr_en;
    logic          rd_en;

    logic [31:0]   diff;
    logic [31:0]   cnt;
    logic [31:0]   start_slot;
    logic [31:0]   tgt;

    assign o_pop = (r_state == ST_IDLE) && i_avail;

    // Batch size and first slot of a peek
    always_comb begin
        diff       = r_write - r_send;
        cnt        = (diff < 32'(i_cmd.limit)) ? diff : 32'(i_cmd.limit);
        start_slot = 32'(r_wslot) + 32'(RING_DEPTH) - diff;
        if (start_slot >= 32'(RING_DEPTH)) begin
            start_slot = start_slot - 32'(RING_DEPTH);
        end
    end

    // Execute one command or step a batch
    always_comb begin
        n_state    = r_state;
        n_write    = r_write;
        n_ack      = r_ack;
        n_send     = r_send;
        n_gap      = r_gap;
        n_wslot    = r_wslot;
        n_slot     = r_slot;
        n_seq      = r_seq;
        n_k        = r_k;
        n_n        = r_n;
        n_base     = r_base;
        n_pk_valid = 1'b0;
        n_pk_seq   = r_pk_seq;
        n_pk_last  = r_pk_last;
        n_st_valid = 1'b0;
        n_st_base  = '0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        tgt        = r_send;
        case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    n_st_valid = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH: begin
                            wr_en   = 1'b1;
                            n_write = r_write + 32'd1;
                            n_wslot = (r_wslot == SW'(RING_DEPTH - 1)) ? '0
                                                                      : r_wslot + 1'b1;
                            // Drop the oldest sample on overflow
                            if ((n_write - r_ack) > 32'(RING_DEPTH)) begin
                                n_ack = n_write - 32'(RING_DEPTH);
                                n_gap = 1'b1;
                                if (seq_after(n_ack, r_send)) begin
                                    n_send = n_ack;
                                end
                            end
                        end
                        OP_PEEK: begin
                            if (cnt == 32'd0) begin
                                n_st_base = r_send;
                            end else begin
                                n_st_valid = 1'b0;
                                n_state    = ST_PEEK;
                                n_slot     = SW'(start_slot);
                                n_seq      = r_send;
                                n_k        = '0;
                                n_n        = 7'(cnt);
                                n_base     = r_send;
                            end
                        end
                        OP_COMMIT: begin
                            if (seq_after(i_cmd.arg, r_send)) begin
                                tgt = i_cmd.arg;
                            end
                            if (seq_after(tgt, r_write)) begin
                                tgt = r_write;
                            end
                            n_send = tgt;
                        end
                        OP_ACK: begin
                            if (seq_after(i_cmd.arg, r_ack) &&
                                seq_not_before(r_write, i_cmd.arg)) begin
                                n_ack = i_cmd.arg;
                                if (seq_after(i_cmd.arg, r_send)) begin
                                    n_send = i_cmd.arg;
                                end
                            end
                        end
                        OP_REWIND: begin
                            n_send = r_ack;
                        end
                        OP_CLEAR: begin
                            n_write = '0;
                            n_ack   = '0;
                            n_send  = '0;
                            n_gap   = 1'b0;
                            n_wslot = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                // Read one sample per cycle
                rd_en      = 1'b1;
                n_pk_valid = 1'b1;
                n_pk_seq   = r_seq;
                n_pk_last  = ((r_k + 7'd1) == r_n);
                n_seq      = r_seq + 32'd1;
                n_k        = r_k + 7'd1;
                n_slot     = (r_slot == SW'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                if ((r_k + 7'd1) == r_n) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_write    <= '0;
            r_ack      <= '0;
            r_send     <= '0;
            r_gap      <= 1'b0;
            r_wslot    <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_pk_valid <= 1'b0;
            r_st_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_write    <= n_write;
            r_ack      <= n_ack;
            r_send     <= n_send;
            r_gap      <= n_gap;
            r_wslot    <= n_wslot;
            r_k        <= n_k;
            r_n        <= n_n;
            r_pk_valid <= n_pk_valid;
            r_st_valid <= n_st_valid;
        end
        r_slot    <= n_slot;
        r_seq     <= n_seq;
        r_base    <= n_base;
        r_pk_seq  <= n_pk_seq;
        r_pk_last <= n_pk_last;
        r_st_base <= n_st_base;
    end

    // Sample store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wslot] <= i_cmd.payload;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r_slot];
        end
    end

    // Drive the result from the batch stage or the status register
    always_comb begin
        o_result_valid       = r_pk_valid || r_st_valid;
        o_result.pending     = 10'(r_write - r_send);
        o_result.unacked     = 10'(r_write - r_ack);
        o_result.gap_seen    = r_gap;
        if (r_pk_valid) begin
            o_result.sample_valid = 1'b1;
            o_result.sample_seq   = r_pk_seq;
            o_result.out_low      = r_rd_data[63:0];
            o_result.out_high     = r_rd_data[95:64];
            o_result.batch_base   = r_base;
            o_result.batch_count  = r_n;
            o_result.last         = r_pk_last;
        end else begin
            o_result.sample_valid = 1'b0;
            o_result.sample_seq   = '0;
            o_result.out_low      = '0;
            o_result.out_high     = '0;
            o_result.batch_base   = r_st_base;
            o_result.batch_count  = '0;
            o_result.last         = 1'b1;
        end
    end

endmodule
